/* rtl/core/ils_pkg.sv */
`timescale 1ns / 1ps
// ils_pkg: shared types and constants for the indexed list store.
// Used by ils_cell and indexed_list_store; depends on nothing.

package ils_pkg;

    // Default sizing of the store
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_HANDLE_BITS = 32;

    // Fixed field widths of the request and result
    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int HIN_W    = 32;
    localparam int COUNT_W  = 7;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    // Register map
    localparam logic [APB_AW-1:0] ADDR_REPORT_EN = 2'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_PUT    = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_REMOVE = 3'd4
    } t_cmd;

    // What every cell of the row does in one update
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_cell_op;

endpackage

/* rtl/core/ils_cell.sv */
`timescale 1ns / 1ps
// ils_cell: one slot of the list; holds a handle and shifts with its neighbors.
// Depends on ils_pkg.

module ils_cell #(
    parameter int IDX         = 0,
    parameter int HANDLE_BITS = ils_pkg::DEF_HANDLE_BITS,
    parameter int CW          = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_upd,
    input  ils_pkg::t_cell_op      i_op,
    input  logic [CW-1:0]          i_tgt,
    input  logic [CW-1:0]          i_len,
    input  logic [HANDLE_BITS-1:0] i_handle,
    input  logic [HANDLE_BITS-1:0] i_left,
    input  logic [HANDLE_BITS-1:0] i_right,
    output logic [HANDLE_BITS-1:0] o_q
);

    localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

    logic [HANDLE_BITS-1:0] r_q;
    logic [HANDLE_BITS-1:0] n_q;

    always_comb begin
        n_q = r_q;
        case (i_op)
            ils_pkg::OP_WRITE: begin
                if (MY_IDX == i_tgt) n_q = i_handle;
            end
            ils_pkg::OP_INSERT: begin
                if (MY_IDX == i_tgt) begin
                    n_q = i_handle;
                end else if (MY_IDX > i_tgt && MY_IDX <= i_len) begin
                    n_q = i_left;
                end
            end
            ils_pkg::OP_REMOVE: begin
                // slots from the target up pull from the right; old top slot clears
                if (MY_IDX >= i_tgt && MY_NEXT < i_len) begin
                    n_q = i_right;
                end else if (MY_NEXT == i_len) begin
                    n_q = '0;
                end
            end
            default: n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_upd) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/core/indexed_list_store.sv */
`timescale 1ns / 1ps
// indexed_list_store: top level; request decode, row of list cells, result register, APB.
// Depends on ils_pkg and ils_cell.

// An ordered list of up to CAPACITY handles. Each request (get, put, append,
// insert, remove) completes in the cycle it is accepted: every cell of the row
// updates at once from its own value or a neighbor's, so insert and remove shift
// the whole list together. Throughput is one request per cycle while not stalled;
// the result shows on the output register in the cycle after the input transfer.
// The only stall on the input side is a full output register that the receiver
// is stalling. Read and released handles come through one selection across the
// row, indexed by the target slot (request position, or length for append).
// The store and length clear at reset with no sweep. Reporting of released
// handles is enabled by the register at byte address 0 (bit 0, reset 1); the user
// must write it only while no request is in flight (the block does not enforce it).

module indexed_list_store #(
    parameter int CAPACITY    = ils_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = ils_pkg::DEF_HANDLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ils_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ils_pkg::POS_W-1:0]   i_position,
    input  logic [ils_pkg::HIN_W-1:0]   i_handle_in,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_ok,
    output logic [ils_pkg::HIN_W-1:0]   o_read_handle,
    output logic                        o_released_valid,
    output logic [ils_pkg::HIN_W-1:0]   o_released_handle,
    output logic [ils_pkg::COUNT_W-1:0] o_list_count,
    // APB register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ils_pkg::APB_AW-1:0]  paddr,
    input  logic [ils_pkg::APB_DW-1:0]  pwdata,
    output logic [ils_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    // compare width: holds a length and any request position
    localparam int CW = (LW > ils_pkg::POS_W) ? LW : ils_pkg::POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // ---------------- register port ----------------
    logic r_report_en;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_en <= 1'b1;
        end else if (w_cfg_wr && paddr == ils_pkg::ADDR_REPORT_EN) begin
            r_report_en <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ils_pkg::ADDR_REPORT_EN) prdata[0] = r_report_en;
    end

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic w_in_acc;

    // output register frees up in the same cycle it is taken
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // ---------------- request decode ----------------
    logic [LW-1:0]          r_len;
    logic [LW-1:0]          n_len;
    logic [CW-1:0]          w_pos;
    logic [CW-1:0]          w_lenx;
    logic [CW-1:0]          w_tgt;
    logic [HANDLE_BITS-1:0] w_h;
    ils_pkg::t_cell_op      w_op;
    logic                   n_ok;
    logic                   n_rd_sel;   // get returns the selected slot
    logic                   n_rel_sel;  // selected slot is released
    logic [HANDLE_BITS-1:0] w_sel_q;

    assign w_pos  = CW'(i_position);
    assign w_lenx = CW'(r_len);
    assign w_h    = HANDLE_BITS'(i_handle_in);

    always_comb begin
        n_ok      = 1'b0;
        n_rd_sel  = 1'b0;
        n_rel_sel = 1'b0;
        w_op      = ils_pkg::OP_HOLD;
        w_tgt     = w_pos;
        n_len     = r_len;
        case (ils_pkg::t_cmd'(i_cmd))
            ils_pkg::CMD_GET: begin
                n_ok     = w_pos < w_lenx;
                n_rd_sel = n_ok;
            end
            ils_pkg::CMD_PUT: begin
                n_ok      = w_pos < CAP_C;
                n_rel_sel = n_ok;
                if (n_ok) begin
                    w_op = ils_pkg::OP_WRITE;
                    if (w_lenx <= w_pos) n_len = LW'(w_pos + CW'(1));
                end
            end
            ils_pkg::CMD_APPEND: begin
                w_tgt     = w_lenx;
                n_ok      = w_lenx < CAP_C;
                n_rel_sel = n_ok;
                if (n_ok) begin
                    w_op  = ils_pkg::OP_WRITE;
                    n_len = r_len + LW'(1);
                end
            end
            ils_pkg::CMD_INSERT: begin
                n_ok = (w_lenx < CAP_C) && (w_pos <= w_lenx);
                if (n_ok) begin
                    w_op  = ils_pkg::OP_INSERT;
                    n_len = r_len + LW'(1);
                end
            end
            ils_pkg::CMD_REMOVE: begin
                n_ok      = w_pos < w_lenx;
                n_rel_sel = n_ok;
                if (n_ok) begin
                    w_op  = ils_pkg::OP_REMOVE;
                    n_len = r_len - LW'(1);
                end
            end
            default: n_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (w_in_acc) begin
            r_len <= n_len;
        end
    end

    // ---------------- row of cells ----------------
    logic [HANDLE_BITS-1:0] w_q [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [HANDLE_BITS-1:0] w_left;
        logic [HANDLE_BITS-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_q[g+1];
        end
        ils_cell #(
            .IDX         (g),
            .HANDLE_BITS (HANDLE_BITS),
            .CW          (CW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_upd    (w_in_acc),
            .i_op     (w_op),
            .i_tgt    (w_tgt),
            .i_len    (w_lenx),
            .i_handle (w_h),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_q      (w_q[g])
        );
    end

    // one selection across the row, at the target slot
    assign w_sel_q = (w_tgt < CAP_C) ? w_q[w_tgt[IW-1:0]] : '0;

    // ---------------- result register ----------------
    logic                      r_ok;
    logic [ils_pkg::HIN_W-1:0] r_rd;
    logic                      r_relv;
    logic [ils_pkg::HIN_W-1:0] r_rel;
    logic [LW-1:0]             r_cnt;
    logic                      n_relv;

    assign n_relv = n_rel_sel && r_report_en && (w_sel_q != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ok   <= n_ok;
            r_rd   <= n_rd_sel ? ils_pkg::HIN_W'(w_sel_q) : '0;
            r_relv <= n_relv;
            r_rel  <= n_relv ? ils_pkg::HIN_W'(w_sel_q) : '0;
            r_cnt  <= n_len;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_ok;
    assign o_read_handle     = r_rd;
    assign o_released_valid  = r_relv;
    assign o_released_handle = r_rel;
    assign o_list_count      = ils_pkg::COUNT_W'(r_cnt);

`ifndef SYNTH
    // a get never changes the length
    a_get_keeps_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_cmd == ils_pkg::CMD_GET) |=> (r_len == $past(r_len)))
        else $error("length changed on get");

    // a failed request carries no read or released handle
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (!o_released_valid && o_read_handle == '0))
        else $error("failed request carries data");

    // the slot just above the list is always empty
    a_top_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_len) < CAP_C) |-> (w_q[r_len[IW-1:0]] == '0))
        else $error("slot above length not empty");
`endif

endmodule
